// ===== rtl/vcsg_pkg.sv =====
// Shared types and constants for the velocity command safety gate.
// No dependencies; imported by every module of the block.
`default_nettype none

package vcsg_pkg;

   localparam int SPEED_W = 16;
   localparam int LIMIT_W = 15;
   localparam int AGE_W   = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 40;

   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_TICKS    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_FORWARD      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_WALK_FORWARD = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DEADBAND_FORWARD = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_YAW          = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DEADBAND_YAW     = 3'd5;

   localparam logic [AGE_W-1:0]   RST_TIMEOUT_TICKS    = 16'd25;
   localparam logic [LIMIT_W-1:0] RST_MAX_FORWARD      = 15'd200;
   localparam logic [LIMIT_W-1:0] RST_MIN_WALK_FORWARD = 15'd250;
   localparam logic [LIMIT_W-1:0] RST_DEADBAND_FORWARD = 15'd30;
   localparam logic [LIMIT_W-1:0] RST_MAX_YAW          = 15'd300;
   localparam logic [LIMIT_W-1:0] RST_DEADBAND_YAW     = 15'd30;

   localparam logic [AGE_W-1:0] AGE_MAX = '1;

   typedef enum logic [1:0] {
      CMD_VELOCITY     = 2'd0,
      CMD_LOCALIZATION = 2'd1,
      CMD_ENABLE       = 2'd2,
      CMD_TICK         = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      ACT_NONE = 2'd0,
      ACT_MOVE = 2'd1,
      ACT_STOP = 2'd2
   } action_type;

   typedef enum logic [2:0] {
      ST_NONE   = 3'd0,
      ST_OK     = 3'd1,
      ST_NO_LOC = 3'd2,
      ST_NO_CMD = 3'd3,
      ST_STALE  = 3'd4
   } status_type;

   typedef struct packed {
      logic [AGE_W-1:0]   timeout_ticks;
      logic [LIMIT_W-1:0] max_forward;
      logic [LIMIT_W-1:0] min_walk_forward;
      logic [LIMIT_W-1:0] deadband_forward;
      logic [LIMIT_W-1:0] max_yaw;
      logic [LIMIT_W-1:0] deadband_yaw;
   } cfg_type;

   typedef struct packed {
      command_type               command;
      logic signed [SPEED_W-1:0] forward_in;
      logic signed [SPEED_W-1:0] yaw_in;
      logic                      command_finite;
      logic                      localization_good;
      logic                      enable_on;
   } req_type;

   typedef struct packed {
      action_type                action;
      logic signed [SPEED_W-1:0] forward_out;
      logic signed [SPEED_W-1:0] yaw_out;
      status_type                response_status;
      logic                      enabled_now;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/vcsg_shaper.sv =====
// Deadband and clamp for stored forward and yaw, minimum-walk floor for forward.
// Purely combinational; depends on vcsg_pkg.
`default_nettype none

module vcsg_shaper
   import vcsg_pkg::*;
(
   input  wire cfg_type                   cfg,
   input  wire logic signed [SPEED_W-1:0] forward,
   input  wire logic signed [SPEED_W-1:0] yaw,
   output logic signed [SPEED_W-1:0]      forward_shaped,
   output logic signed [SPEED_W-1:0]      yaw_shaped
);

   logic [SPEED_W-1:0]        fwd_mag;
   logic [SPEED_W-1:0]        fwd_floor;
   logic [SPEED_W-1:0]        fwd_cap;
   logic [SPEED_W-1:0]        yaw_mag;
   logic signed [SPEED_W-1:0] yaw_lim_pos;
   logic signed [SPEED_W-1:0] yaw_lim_neg;

   always_comb begin
      fwd_mag   = forward[SPEED_W-1] ? SPEED_W'(-forward) : SPEED_W'(forward);
      fwd_floor = (fwd_mag < {1'b0, cfg.min_walk_forward}) ?
                  {1'b0, cfg.min_walk_forward} : fwd_mag;
      fwd_cap   = (fwd_floor > {1'b0, cfg.max_forward}) ?
                  {1'b0, cfg.max_forward} : fwd_floor;
      if (fwd_mag < {1'b0, cfg.deadband_forward}) begin
         forward_shaped = '0;
      end else if (forward[SPEED_W-1]) begin
         forward_shaped = -$signed(fwd_cap);
      end else begin
         forward_shaped = $signed(fwd_cap);
      end

      yaw_mag     = yaw[SPEED_W-1] ? SPEED_W'(-yaw) : SPEED_W'(yaw);
      yaw_lim_pos = $signed({1'b0, cfg.max_yaw});
      yaw_lim_neg = -yaw_lim_pos;
      if (yaw_mag < {1'b0, cfg.deadband_yaw}) begin
         yaw_shaped = '0;
      end else if (yaw > yaw_lim_pos) begin
         yaw_shaped = yaw_lim_pos;
      end else if (yaw < yaw_lim_neg) begin
         yaw_shaped = yaw_lim_neg;
      end else begin
         yaw_shaped = yaw;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/vcsg_core.sv =====
// Gate state (enable, localization, stored command, age) and per-event decision.
// Depends on vcsg_pkg and vcsg_shaper.
`default_nettype none

module vcsg_core
   import vcsg_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    fire,
   input  wire req_type req,
   input  wire cfg_type cfg,
   output rsp_type      rsp
);

   logic                      enabled_ff, enabled_in;
   logic                      localized_ff, localized_in;
   logic                      have_command_ff, have_command_in;
   logic signed [SPEED_W-1:0] last_forward_ff, last_forward_in;
   logic signed [SPEED_W-1:0] last_yaw_ff, last_yaw_in;
   logic [AGE_W-1:0]          command_age_ff, command_age_in;

   logic signed [SPEED_W-1:0] fwd_shaped;
   logic signed [SPEED_W-1:0] yaw_shaped;
   logic                      stale;

   vcsg_shaper u_shaper (
      .cfg            (cfg),
      .forward        (last_forward_ff),
      .yaw            (last_yaw_ff),
      .forward_shaped (fwd_shaped),
      .yaw_shaped     (yaw_shaped)
   );

   assign stale = command_age_ff > cfg.timeout_ticks;

   always_comb begin
      enabled_in      = enabled_ff;
      localized_in    = localized_ff;
      have_command_in = have_command_ff;
      last_forward_in = last_forward_ff;
      last_yaw_in     = last_yaw_ff;
      command_age_in  = command_age_ff;
      rsp.action          = ACT_NONE;
      rsp.forward_out     = '0;
      rsp.yaw_out         = '0;
      rsp.response_status = ST_NONE;

      case (req.command)
         CMD_VELOCITY: begin
            if (req.command_finite) begin
               last_forward_in = req.forward_in;
               last_yaw_in     = req.yaw_in;
               have_command_in = 1'b1;
               command_age_in  = '0;
            end
         end
         CMD_LOCALIZATION: begin
            localized_in = req.localization_good;
            if (localized_ff && !req.localization_good) begin
               enabled_in = 1'b0;
               rsp.action = ACT_STOP;
            end
         end
         CMD_ENABLE: begin
            if (!req.enable_on) begin
               rsp.response_status = ST_OK;
            end else if (!localized_ff) begin
               rsp.response_status = ST_NO_LOC;
            end else if (!have_command_ff) begin
               rsp.response_status = ST_NO_CMD;
            end else if (stale) begin
               rsp.response_status = ST_STALE;
            end
            if (rsp.response_status != ST_NONE) begin
               enabled_in = 1'b0;
               rsp.action = ACT_STOP;
            end else begin
               enabled_in          = 1'b1;
               rsp.response_status = ST_OK;
            end
         end
         CMD_TICK: begin
            if (!enabled_ff) begin
               rsp.action = ACT_STOP;
            end else if (!localized_ff) begin
               enabled_in = 1'b0;
               rsp.action = ACT_STOP;
            end else if (!have_command_ff || stale) begin
               rsp.action = ACT_STOP;
            end else if (fwd_shaped == '0 && yaw_shaped == '0) begin
               rsp.action = ACT_STOP;
            end else begin
               rsp.action      = ACT_MOVE;
               rsp.forward_out = fwd_shaped;
               rsp.yaw_out     = yaw_shaped;
            end
            if (command_age_ff != AGE_MAX) begin
               command_age_in = command_age_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase

      rsp.enabled_now = enabled_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff      <= 1'b0;
         localized_ff    <= 1'b0;
         have_command_ff <= 1'b0;
         last_forward_ff <= '0;
         last_yaw_ff     <= '0;
         command_age_ff  <= '0;
      end else if (fire) begin
         enabled_ff      <= enabled_in;
         localized_ff    <= localized_in;
         have_command_ff <= have_command_in;
         last_forward_ff <= last_forward_in;
         last_yaw_ff     <= last_yaw_in;
         command_age_ff  <= command_age_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/velocity_command_safety_gate.sv =====
// Velocity command safety gate: input register, event logic, result register.
// Accepted requests pass the input register, then the result register; throughput one
// request per cycle while rsp_tready is high, set by the single event stage in between.
// Synchronous active-high reset clears the gate state, both pipeline valids and
// loads the configuration registers with their defaults. Depends on vcsg_pkg, vcsg_core.
`default_nettype none

module velocity_command_safety_gate
   import vcsg_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // forward_in[15:0], yaw_in[31:16], command_finite[32], localization_good[33],
   // enable_on[34], zero[39:35]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // command[1:0]
   input  wire logic [1:0]            req_tuser,

   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // forward_out[15:0], yaw_out[31:16], response_status[34:32], enabled_now[35],
   // zero[39:36]
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // action[1:0]
   output logic [1:0]                 rsp_tuser,

   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type cfg_ff;
   req_type req_ff, req_in;
   logic    in_valid_ff;
   rsp_type rsp_ff, rsp_in;
   logic    out_valid_ff;
   logic    advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_ticks    <= RST_TIMEOUT_TICKS;
         cfg_ff.max_forward      <= RST_MAX_FORWARD;
         cfg_ff.min_walk_forward <= RST_MIN_WALK_FORWARD;
         cfg_ff.deadband_forward <= RST_DEADBAND_FORWARD;
         cfg_ff.max_yaw          <= RST_MAX_YAW;
         cfg_ff.deadband_yaw     <= RST_DEADBAND_YAW;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TIMEOUT_TICKS:    cfg_ff.timeout_ticks    <= csr_wdata;
            CSR_MAX_FORWARD:      cfg_ff.max_forward      <= csr_wdata[LIMIT_W-1:0];
            CSR_MIN_WALK_FORWARD: cfg_ff.min_walk_forward <= csr_wdata[LIMIT_W-1:0];
            CSR_DEADBAND_FORWARD: cfg_ff.deadband_forward <= csr_wdata[LIMIT_W-1:0];
            CSR_MAX_YAW:          cfg_ff.max_yaw          <= csr_wdata[LIMIT_W-1:0];
            CSR_DEADBAND_YAW:     cfg_ff.deadband_yaw     <= csr_wdata[LIMIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      req_in.command           = command_type'(req_tuser);
      req_in.forward_in        = $signed(req_tdata[15:0]);
      req_in.yaw_in            = $signed(req_tdata[31:16]);
      req_in.command_finite    = req_tdata[32];
      req_in.localization_good = req_tdata[33];
      req_in.enable_on         = req_tdata[34];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         req_ff <= req_in;
      end
   end

   vcsg_core u_core (
      .clock (clock),
      .reset (reset),
      .fire  (advance),
      .req   (req_ff),
      .cfg   (cfg_ff),
      .rsp   (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = rsp_ff.action;
   assign rsp_tdata  = {4'b0000, rsp_ff.enabled_now, rsp_ff.response_status,
                        rsp_ff.yaw_out, rsp_ff.forward_out};

   a_speeds_only_on_move: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ACT_MOVE |-> rsp_tdata[31:0] == '0)
      else $error("nonzero speed on a non-move response");

   a_move_needs_enable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ACT_MOVE |-> rsp_tdata[35] && rsp_tdata[34:32] == ST_NONE)
      else $error("move response while disabled or with a status");

   a_stalled_request_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(req_ff))
      else $error("stalled request lost or changed");

   a_accept_loads_stage: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> in_valid_ff)
      else $error("accepted request not held in input stage");

endmodule

`default_nettype wire
